// File: sv/lkvc_pkg.sv
// lkvc_pkg: shared types for the lru key/value cache
// used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache; no dependencies
package lkvc_pkg;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // operation codes of the func field
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   // reset value of the capacity register
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // capture the incoming word
      logic lookup;   // key compare, victim and free slot search, value read
      logic commit;   // apply the update and load the result register
   } cmd_type;

endpackage

// File: sv/lkvc_ctrl.sv
// lkvc_ctrl: sequencing state machine and result valid for the cache
// depends on lkvc_pkg
module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lkvc_pkg::cmd_type cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic commit;

   // result register can take a new word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // input is taken when idle or as the previous word commits
   assign req_stall = !((state_ff == lkvc_pkg::ST_IDLE) ||
                        ((state_ff == lkvc_pkg::ST_UPDATE) && out_free));
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == lkvc_pkg::ST_UPDATE) && out_free;

   assign cmd.accept = accept;
   assign cmd.lookup = (state_ff == lkvc_pkg::ST_LOOKUP);
   assign cmd.commit = commit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (accept) state_in = lkvc_pkg::ST_LOOKUP;
         end
         lkvc_pkg::ST_LOOKUP: begin
            state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (commit) state_in = accept ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   // result valid: set on commit, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/lkvc_datapath.sv
// lkvc_datapath: key lanes with parallel compare, age ranks, value memory,
// capacity register and result register; depends on lkvc_pkg
module lkvc_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  lkvc_pkg::cmd_type  cmd,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_capacity,
   input  logic               req_func,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value
);

   localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;

   // captured word
   logic        func_ff;
   logic [31:0] key_ff;
   logic [31:0] value_ff;

   // per-entry state
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]        key_lane_ff [ENTRIES];
   logic [IW-1:0]      rank_ff     [ENTRIES];
   logic [CW-1:0]      count_ff;
   logic [4:0]         cap_ff;

   // value store
   logic [31:0] value_mem [ENTRIES];
   logic [31:0] rdata_ff;

   // lookup results
   logic               hit_ff;
   logic [ENTRIES-1:0] match_ff;
   logic [IW-1:0]      hit_idx_ff;
   logic               evict_ff;
   logic [ENTRIES-1:0] evict_vec_ff;
   logic [ENTRIES-1:0] free_vec_ff;
   logic [IW-1:0]      free_idx_ff;

   // result register
   logic        rsp_hit_ff;
   logic [31:0] rsp_value_ff;

   logic [ENTRIES-1:0] match;
   logic [IW-1:0]      hit_idx;
   logic [CMPW-1:0]    cap_ext;
   logic [CMPW-1:0]    eff_cap;
   logic [CMPW-1:0]    count_ext;
   logic               need_evict;
   logic [CW-1:0]      count_m1;
   logic [IW-1:0]      oldest_rank;
   logic [ENTRIES-1:0] evict_vec;
   logic [ENTRIES-1:0] avail;
   logic [ENTRIES-1:0] free_vec;
   logic [IW-1:0]      free_idx;
   logic [IW-1:0]      hit_rank;
   logic               insert;

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_capacity;
      end
   end

   // parallel key compare and hit index
   always_comb begin
      match   = '0;
      hit_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_lane_ff[i] == key_ff);
         if (match[i]) hit_idx = hit_idx | IW'(i);
      end
   end

   // capacity clamped to 1 .. ENTRIES; evict when the live count is at or above it
   always_comb begin
      cap_ext   = CMPW'(cap_ff);
      count_ext = CMPW'(count_ff);
      if (cap_ext == '0) begin
         eff_cap = CMPW'(1);
      end else if (cap_ext > CMPW'(ENTRIES)) begin
         eff_cap = CMPW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      need_evict  = (count_ext >= eff_cap);
      count_m1    = count_ff - CW'(1);
      oldest_rank = count_m1[IW-1:0];
   end

   // victim and lowest free slot after eviction
   always_comb begin
      evict_vec = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         evict_vec[i] = need_evict && valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
      avail    = ~valid_ff | evict_vec;
      free_vec = avail & (~avail + ENTRIES'(1));
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_vec[i]) free_idx = free_idx | IW'(i);
      end
   end

   // register lookup results
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff       <= |match;
         match_ff     <= match;
         hit_idx_ff   <= hit_idx;
         evict_ff     <= need_evict;
         evict_vec_ff <= evict_vec;
         free_vec_ff  <= free_vec;
         free_idx_ff  <= free_idx;
      end
   end

   // value memory: read during lookup, write on commit of a set
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rdata_ff <= value_mem[hit_idx];
      end
      if (cmd.commit && (func_ff == lkvc_pkg::FUNC_SET)) begin
         value_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= value_ff;
      end
   end

   // age of the entry being touched
   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) hit_rank = hit_rank | rank_ff[i];
      end
   end

   assign insert = !hit_ff && (func_ff == lkvc_pkg::FUNC_SET);

   // valid bits, age ranks and live count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else if (cmd.commit) begin
         if (insert && !evict_ff) count_ff <= count_ff + CW'(1);
         for (int i = 0; i < ENTRIES; i++) begin
            if (hit_ff) begin
               if (match_ff[i]) begin
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_ff[i] <= rank_ff[i] + IW'(1);
               end
            end else if (insert) begin
               if (free_vec_ff[i]) begin
                  valid_ff[i] <= 1'b1;
                  rank_ff[i]  <= '0;
               end else if (evict_vec_ff[i]) begin
                  valid_ff[i] <= 1'b0;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i]) begin
                  rank_ff[i] <= rank_ff[i] + IW'(1);
               end
            end
         end
      end
   end

   // key lanes, written on insert
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && insert && free_vec_ff[i]) key_lane_ff[i] <= key_ff;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit_ff;
         if (func_ff == lkvc_pkg::FUNC_SET) begin
            rsp_value_ff <= '0;
         end else if (hit_ff) begin
            rsp_value_ff <= rdata_ff;
         end else begin
            rsp_value_ff <= '1;
         end
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// File: sv/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key/value store, lru replacement
// a taken word goes through a lookup state for the key compare over all
// entries and the value read, then an update state for the age-rank update
// and write; the next word can be taken as the previous one commits
// reset: valid bits, ranks and live count cleared at once, capacity 16
// depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_capacity
);

   lkvc_pkg::cmd_type cmd;

   // sequencing
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // storage and compare
   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_capacity     (csr_capacity),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value)
   );

   // an accepted word goes to lookup next
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.lookup)
      else $error("accepted word not followed by lookup");

   // a lookup is never repeated back to back
   a_single_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> !cmd.lookup)
      else $error("lookup held over two cycles");

   // a commit always presents a result
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without result valid");

   // no word taken during lookup
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |-> req_stall)
      else $error("input not stalled during lookup");

endmodule

// File: test/lru_key_value_cache_tb.sv
// lru_key_value_cache_tb: self-checking bench for the lru key/value cache
// a directed table, then random get/set words over several capacity settings
// depends on lkvc_pkg and lru_key_value_cache
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS          = 16;
   localparam int POOL_SIZE      = 24;
   localparam int PHASES         = 8;
   localparam int WORDS_PER_PHASE = 231;
   localparam int WATCHDOG_LIMIT = 2000;

   // operation codes for the table rows
   localparam logic OP_GET = lkvc_pkg::FUNC_GET;
   localparam logic OP_SET = lkvc_pkg::FUNC_SET;

   // kinds of row in the directed table
   typedef enum logic {
      ROW_ACCESS,
      ROW_CAPACITY
   } row_kind_type;

   // where a row's expected reply comes from
   typedef enum logic {
      CHK_PREDICT,
      CHK_FIXED
   } check_kind_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
   } cache_reply_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [4:0]     cap;
      logic           func;
      logic [31:0]    key;
      logic [31:0]    value;
      check_kind_type check;
      logic           hit;
      logic [31:0]    read_value;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 29;

   // directed words: extremes, update, capacity below live count, zero and oversize capacity
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, CHK_FIXED,   1'b0, 32'hFFFF_FFFF},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, CHK_FIXED,   1'b0, 32'hFFFF_FFFF},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, CHK_FIXED,   1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, CHK_FIXED,   1'b1, 32'h8000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, CHK_FIXED,   1'b1, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, CHK_FIXED,   1'b1, 32'h7FFF_FFFF},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h8000_0000, 32'hFFFF_FFFF, CHK_FIXED,   1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, CHK_FIXED,   1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h8000_0000, 32'h0000_0000, CHK_FIXED,   1'b1, 32'hFFFF_FFFF},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, CHK_FIXED,   1'b1, 32'h0000_0000},
      '{ROW_CAPACITY, 5'd2,  OP_GET, 32'h0000_0000, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0005, 32'h0000_0037, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0006, 32'h0000_0042, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_CAPACITY, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0007, 32'h1234_5678, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0007, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0006, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_CAPACITY, 5'd31, OP_GET, 32'h0000_0000, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0001, 32'hDEAD_BEEF, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0002, 32'h0BAD_F00D, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0007, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0007, 32'h5555_AAAA, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0001, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_CAPACITY, 5'd1,  OP_GET, 32'h0000_0000, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_SET, 32'h0000_0009, 32'hAAAA_5555, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0009, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000},
      '{ROW_ACCESS,   5'd0,  OP_GET, 32'h0000_0002, 32'h0000_0000, CHK_PREDICT, 1'b0, 32'h0000_0000}
   };

   // capacity per random phase; the sixth is drawn at random
   logic [4:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd0, 5'd16, 5'd8};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hit;
   logic [31:0] rsp_read_value;
   logic        csr_write_enable;
   logic [4:0]  csr_capacity;

   // predictor state
   logic        slot_live  [SLOTS];
   logic [31:0] slot_key   [SLOTS];
   logic [31:0] slot_value [SLOTS];
   int          slot_rank  [SLOTS];
   logic [4:0]  cap_setting;

   cache_reply_type reply_q [$];
   logic [31:0]     key_pool [POOL_SIZE];
   bit              gaps_on;
   int              mismatch_count;
   int              quiet_cycles;

   lru_key_value_cache #(
      .ENTRIES(SLOTS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_write_enable(csr_write_enable),
      .csr_capacity    (csr_capacity)
   );

   always #1 clock = ~clock;

   // make one slot the most recent; younger live slots age by one
   function automatic void make_recent(input int s);
      int r;
      r = slot_rank[s];
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endfunction

   // expected reply of one get or set, updating the predicted cache contents
   function automatic cache_reply_type predict_access(input logic func, input logic [31:0] key,
                                                      input logic [31:0] value);
      cache_reply_type reply;
      logic            found;
      int              slot;
      int              live;
      int              limit;
      int              free_slot;
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && slot_key[i] == key) begin
            found = 1'b1;
            slot  = i;
         end
      end
      reply.hit = found;
      if (func == lkvc_pkg::FUNC_GET) begin
         reply.read_value = found ? slot_value[slot] : 32'hFFFF_FFFF;
         if (found) make_recent(slot);
         return reply;
      end
      reply.read_value = 32'h0;
      if (found) begin
         slot_value[slot] = value;
         make_recent(slot);
         return reply;
      end
      // insert: evict the oldest first when full or at capacity
      live = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live++;
      limit = (cap_setting == 0) ? 1 : (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
      if (live >= SLOTS || live + 1 > limit) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_rank[i] == live - 1) begin
               slot_live[i] = 1'b0;
               slot_rank[i] = 0;
            end
         end
      end
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) if (!slot_live[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return reply;
      for (int i = 0; i < SLOTS; i++) if (slot_live[i]) slot_rank[i]++;
      slot_live[free_slot]  = 1'b1;
      slot_key[free_slot]   = key;
      slot_value[free_slot] = value;
      slot_rank[free_slot]  = 0;
      return reply;
   endfunction

   // offer one word, wait for it to be taken, queue its expected reply
   task automatic send_word(input logic func, input logic [31:0] key, input logic [31:0] value,
                            input check_kind_type check, input cache_reply_type fixed_reply);
      cache_reply_type predicted;
      while (gaps_on && $urandom_range(0, 99) < 31) @(negedge clock);
      req_valid = 1'b1;
      req_func  = func;
      req_key   = key;
      req_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_access(func, key, value);
      reply_q.push_back((check == CHK_FIXED) ? fixed_reply : predicted);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // drain outstanding replies, then write the capacity register
   task automatic write_capacity(input logic [4:0] cap);
      while (reply_q.size() != 0) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_capacity     = cap;
      @(negedge clock);
      csr_write_enable = 1'b0;
      cap_setting      = cap;
   endtask

   // result side stalls at random
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 31);
   end

   // reply checker and watchdog
   always @(posedge clock) begin
      cache_reply_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected reply word hit %0d read_value %h", $time, rsp_hit,
                        rsp_read_value);
               mismatch_count++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: rsp_hit expected %0d actual %0d", $time, want.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: rsp_read_value expected %h actual %h", $time,
                           want.read_value, rsp_read_value);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      cache_reply_type fixed;
      logic [4:0]      cap;
      logic [31:0]     key;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = lkvc_pkg::FUNC_GET;
      req_key          = 32'h0;
      req_value        = 32'h0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_capacity     = lkvc_pkg::CAPACITY_RESET;
      gaps_on          = 1'b1;
      mismatch_count   = 0;
      quiet_cycles     = 0;
      cap_setting      = lkvc_pkg::CAPACITY_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i]  = 1'b0;
         slot_key[i]   = 32'h0;
         slot_value[i] = 32'h0;
         slot_rank[i]  = 0;
      end
      // key pool: extremes plus random keys, small enough to hit often
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h7FFF_FFFF;
      key_pool[3] = 32'h8000_0000;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CAPACITY) begin
            write_capacity(directed_rows[r].cap);
         end else begin
            fixed.hit        = directed_rows[r].hit;
            fixed.read_value = directed_rows[r].read_value;
            send_word(directed_rows[r].func, directed_rows[r].key, directed_rows[r].value,
                      directed_rows[r].check, fixed);
         end
      end

      // random phases, one of them with no idling on either side
      fixed = '0;
      for (int ph = 0; ph < PHASES; ph++) begin
         cap = (ph == 5) ? 5'($urandom_range(0, 31)) : phase_caps[ph];
         write_capacity(cap);
         gaps_on = (ph != 6);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : 32'($urandom);
            send_word(1'($urandom_range(0, 1)), key, 32'($urandom), CHK_PREDICT, fixed);
         end
      end
      gaps_on = 1'b1;

      // wait out the remaining replies, then watch for strays
      while (reply_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
